>>> hw/rtl/ceu_pkg.sv
// Shared types and constants for the CHIP-8 execute unit.
// Holds the word structs, opcode and status codes; depends on nothing else.
`default_nettype none

package ceu_pkg;

  localparam int unsigned AddrWidth = 12;
  localparam int unsigned RegCount  = 16;

  // High nibble of an instruction word.
  typedef enum logic [3:0] {
    OP_SYS     = 4'h0,
    OP_JP      = 4'h1,
    OP_CALL    = 4'h2,
    OP_SE_KK   = 4'h3,
    OP_SNE_KK  = 4'h4,
    OP_SE_XY   = 4'h5,
    OP_LD_KK   = 4'h6,
    OP_ADD_KK  = 4'h7,
    OP_ALU     = 4'h8,
    OP_SNE_XY  = 4'h9,
    OP_LD_I    = 4'hA,
    OP_JP_V0   = 4'hB,
    OP_RND     = 4'hC,
    OP_DRW     = 4'hD,
    OP_KEY     = 4'hE,
    OP_MISC    = 4'hF
  } op_e;

  // Low nibble of an 8xyN word.
  typedef enum logic [3:0] {
    ALU_LD   = 4'h0,
    ALU_OR   = 4'h1,
    ALU_AND  = 4'h2,
    ALU_XOR  = 4'h3,
    ALU_ADD  = 4'h4,
    ALU_SUB  = 4'h5,
    ALU_SHR  = 4'h6,
    ALU_SUBN = 4'h7,
    ALU_SHL  = 4'hE
  } alu_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_OVERFLOW    = 2'd2,
    ST_UNDERFLOW   = 2'd3
  } status_e;

  localparam logic [15:0] RetWord = 16'h00EE;
  localparam logic [3:0]  FlagReg = 4'hF;
  localparam logic [11:0] PcReset = 12'd512;

  typedef struct packed {
    logic [15:0] instruction;
    logic [7:0]  random_byte;
  } in_word_t;

  typedef struct packed {
    logic [11:0] next_pc;
    logic [11:0] index_value;
    logic [3:0]  written_reg;
    logic [7:0]  written_value;
    logic        reg_written;
    status_e     status;
  } out_word_t;

endpackage

`default_nettype wire

>>> hw/rtl/ceu_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the return stack of the CHIP-8 execute unit; no dependencies.
`default_nettype none

module ceu_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hw/rtl/chip8_execute_unit.sv
// CHIP-8 instruction execute unit: top level, uses ceu_pkg and ceu_ram.
// A taken word waits in the input register; its result is loaded into the output register once that can take it.
// Throughput: one instruction word per cycle while the output is not stalled.
// Reset: program counter loads 512, V registers, index and stack level clear to zero.
// Return stack contents are undefined after reset; only pushed entries are ever used as return addresses.
// Writing entry_address reloads the program counter immediately.
`default_nettype none

module chip8_execute_unit #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration: entry address
  input  wire logic               cfg_we_i,
  input  wire logic [11:0]        cfg_wdata_i,
  // Instruction words in
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire ceu_pkg::in_word_t  in_data_i,
  // Result words out
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      ceu_pkg::out_word_t out_data_o
);

  // Stack level counts 0..STACK_DEPTH, the RAM address only 0..STACK_DEPTH-1.
  localparam int unsigned LvlWidth = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SpWidth  = $clog2(STACK_DEPTH);
  localparam logic [LvlWidth-1:0] LvlFull = LvlWidth'(STACK_DEPTH);

  // ---------------------------------------------------------------------------
  // Input register. The word waits here until the output register can take
  // its result; the architectural state is updated in that same cycle.
  // ---------------------------------------------------------------------------
  logic              in_valid_q, in_valid_d;
  ceu_pkg::in_word_t in_word_q;
  logic              in_take;
  logic              advance;

  logic               out_valid_q, out_valid_d;
  ceu_pkg::out_word_t out_word_q, out_word_d;

  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign in_take    = in_valid_i & ~in_stall_o;
  assign in_valid_d = in_take | (in_valid_q & ~advance);

  // ---------------------------------------------------------------------------
  // Architectural state.
  // ---------------------------------------------------------------------------
  logic [11:0]         entry_q;
  logic [11:0]         pc_q, pc_d;
  logic [11:0]         index_q, index_d;
  logic [7:0]          vregs_q [ceu_pkg::RegCount];
  logic [LvlWidth-1:0] level_q, level_d;
  // The top of the return stack is kept in a register so a return needs no
  // RAM read in its own cycle. The RAM keeps reading the entry below the top
  // so a following return finds it ready.
  logic [11:0]         top_q, top_d;

  logic                stk_we;
  logic [11:0]         stk_rdata;
  logic [LvlWidth-1:0] rd_level;
  logic [SpWidth-1:0]  stk_raddr;

  assign rd_level  = level_d - LvlWidth'(2);
  assign stk_raddr = rd_level[SpWidth-1:0];

  ceu_ram #(
    .WIDTH (12),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (level_q[SpWidth-1:0]),
    .wdata_i (top_d),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // ---------------------------------------------------------------------------
  // Decode and execute.
  // ---------------------------------------------------------------------------
  ceu_pkg::op_e     op;
  ceu_pkg::alu_e    alu_op;
  ceu_pkg::status_e status;
  logic [11:0]      nnn;
  logic [7:0]       kk;
  logic [3:0]       x_idx, y_idx, n_low;
  logic [7:0]       vx, vy;
  logic [11:0]      pc_adv;
  logic [8:0]       sum9;
  logic             skip;
  logic             wr;
  logic [7:0]       wval;
  logic             flag_we;
  logic             flag_val;
  logic             push, pop;

  assign op     = ceu_pkg::op_e'(in_word_q.instruction[15:12]);
  assign alu_op = ceu_pkg::alu_e'(in_word_q.instruction[3:0]);
  assign nnn    = in_word_q.instruction[11:0];
  assign kk     = in_word_q.instruction[7:0];
  assign x_idx  = in_word_q.instruction[11:8];
  assign y_idx  = in_word_q.instruction[7:4];
  assign n_low  = in_word_q.instruction[3:0];
  assign vx     = vregs_q[x_idx];
  assign vy     = vregs_q[y_idx];
  assign pc_adv = pc_q + 12'd2;
  assign sum9   = {1'b0, vx} + {1'b0, vy};

  always_comb begin
    status   = ceu_pkg::ST_OK;
    skip     = 1'b0;
    wr       = 1'b0;
    wval     = 8'd0;
    flag_we  = 1'b0;
    flag_val = 1'b0;
    push     = 1'b0;
    pop      = 1'b0;
    pc_d     = pc_adv;
    index_d  = index_q;

    unique case (op)
      ceu_pkg::OP_SYS: begin
        if (in_word_q.instruction == ceu_pkg::RetWord) begin
          if (level_q == '0) begin
            status = ceu_pkg::ST_UNDERFLOW;
          end else begin
            pop  = 1'b1;
            pc_d = top_q;
          end
        end else begin
          status = ceu_pkg::ST_UNSUPPORTED;
        end
      end
      ceu_pkg::OP_JP: pc_d = nnn;
      ceu_pkg::OP_CALL: begin
        if (level_q == LvlFull) begin
          status = ceu_pkg::ST_OVERFLOW;
        end else begin
          push = 1'b1;
          pc_d = nnn;
        end
      end
      ceu_pkg::OP_SE_KK:  skip = (vx == kk);
      ceu_pkg::OP_SNE_KK: skip = (vx != kk);
      ceu_pkg::OP_SE_XY: begin
        if (n_low == 4'd0) begin
          skip = (vx == vy);
        end else begin
          status = ceu_pkg::ST_UNSUPPORTED;
        end
      end
      ceu_pkg::OP_LD_KK: begin
        wr   = 1'b1;
        wval = kk;
      end
      ceu_pkg::OP_ADD_KK: begin
        wr   = 1'b1;
        wval = vx + kk;
      end
      ceu_pkg::OP_ALU: begin
        unique case (alu_op)
          ceu_pkg::ALU_LD: begin
            wr   = 1'b1;
            wval = vy;
          end
          ceu_pkg::ALU_OR: begin
            wr   = 1'b1;
            wval = vx | vy;
          end
          ceu_pkg::ALU_AND: begin
            wr   = 1'b1;
            wval = vx & vy;
          end
          ceu_pkg::ALU_XOR: begin
            wr   = 1'b1;
            wval = vx ^ vy;
          end
          ceu_pkg::ALU_ADD: begin
            flag_we  = 1'b1;
            flag_val = sum9[8];
            wr       = 1'b1;
            wval     = sum9[7:0];
          end
          ceu_pkg::ALU_SUB: begin
            flag_we  = 1'b1;
            flag_val = (vx > vy);
            wr       = 1'b1;
            wval     = vx - vy;
          end
          ceu_pkg::ALU_SHR: begin
            flag_we  = 1'b1;
            flag_val = vx[0];
            wr       = 1'b1;
            wval     = {1'b0, vx[7:1]};
          end
          ceu_pkg::ALU_SUBN: begin
            flag_we  = 1'b1;
            flag_val = (vy > vx);
            wr       = 1'b1;
            wval     = vy - vx;
          end
          ceu_pkg::ALU_SHL: begin
            flag_we  = 1'b1;
            flag_val = vx[7];
            wr       = 1'b1;
            wval     = {vx[6:0], 1'b0};
          end
          default: status = ceu_pkg::ST_UNSUPPORTED;
        endcase
      end
      ceu_pkg::OP_SNE_XY: begin
        if (n_low == 4'd0) begin
          skip = (vx != vy);
        end else begin
          status = ceu_pkg::ST_UNSUPPORTED;
        end
      end
      ceu_pkg::OP_LD_I:  index_d = nnn;
      ceu_pkg::OP_JP_V0: pc_d = nnn + {4'd0, vregs_q[0]};
      ceu_pkg::OP_RND: begin
        wr   = 1'b1;
        wval = in_word_q.random_byte & kk;
      end
      default: status = ceu_pkg::ST_UNSUPPORTED;
    endcase

    if (skip) begin
      pc_d = pc_adv + 12'd2;
    end
  end

  // Stack bookkeeping. A push stores the return address both in the RAM and
  // in the top register; a pop takes the new top from the prefetched RAM read.
  always_comb begin
    level_d = level_q;
    top_d   = top_q;
    stk_we  = 1'b0;
    if (advance && push) begin
      level_d = level_q + LvlWidth'(1);
      top_d   = pc_adv;
      stk_we  = 1'b1;
    end else if (advance && pop) begin
      level_d = level_q - LvlWidth'(1);
      top_d   = stk_rdata;
    end
  end

  always_comb begin
    out_word_d.next_pc       = pc_d;
    out_word_d.index_value   = index_d;
    out_word_d.written_reg   = wr ? x_idx : 4'd0;
    out_word_d.written_value = wr ? wval : 8'd0;
    out_word_d.reg_written   = wr;
    out_word_d.status        = status;
  end

  assign out_valid_d = advance | (out_valid_q & out_stall_i);

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      entry_q     <= ceu_pkg::PcReset;
      pc_q        <= ceu_pkg::PcReset;
      index_q     <= 12'd0;
      level_q     <= '0;
      for (int i = 0; i < ceu_pkg::RegCount; i++) begin
        vregs_q[i] <= 8'd0;
      end
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        // The user must write configuration only while the unit is idle; the unit does not enforce it.
        entry_q <= cfg_wdata_i;
        pc_q    <= cfg_wdata_i;
      end else if (advance) begin
        pc_q <= pc_d;
      end
      if (advance) begin
        index_q <= index_d;
        level_q <= level_d;
        // VF takes the flag unless it is also the destination, in which case
        // the result value wins.
        if (flag_we && (x_idx != ceu_pkg::FlagReg)) begin
          vregs_q[ceu_pkg::FlagReg] <= {7'd0, flag_val};
        end
        if (wr) begin
          vregs_q[x_idx] <= wval;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_data_i;
    end
    if (advance) begin
      out_word_q <= out_word_d;
    end
    top_q <= top_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LvlFull)
    else $error("return stack level beyond depth");

  a_push_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && push) |=> (level_q == $past(level_q) + LvlWidth'(1)))
    else $error("call did not raise the stack level");

  a_overflow_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && status == ceu_pkg::ST_OVERFLOW) |=> $stable(level_q))
    else $error("stack level moved on overflow");

  a_result_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("executed word produced no result");

  a_word_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_word_q)))
    else $error("waiting instruction word was lost");

  entry_unused_note : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (pc_q == entry_q))
    else $error("program counter not reloaded from entry address");

endmodule

`default_nettype wire
